/* rtl/xdm_pkg.sv */
// Shared constants, types and tables of the turret-centric X-drive mixer.
package xdm_pkg;

    localparam int AXIS_FRAC_BITS = 11;
    localparam int ANGLE_BITS     = 16;
    localparam int AX_W           = AXIS_FRAC_BITS + 2;
    localparam int CFG_W          = 14;
    localparam int COEF_W         = 12;
    localparam int CFG_IDX_W      = 2;

    // magnitude: root of (x*x + y*y) * 2^16
    localparam int SQ_W         = 2 * AXIS_FRAC_BITS + 2;
    localparam int MAG_SHIFT    = 16;
    localparam int RAD_W        = SQ_W + MAG_SHIFT;
    localparam int ROOT_W       = RAD_W / 2;
    localparam int REM_W        = ROOT_W + 4;
    localparam int SQRT_PER_STG = 4;
    localparam int SQRT_STG     = (ROOT_W + SQRT_PER_STG - 1) / SQRT_PER_STG;

    // spin falloff divider
    localparam int CS_W        = COEF_W + AXIS_FRAC_BITS;
    localparam int DEN_W       = CS_W + 1;
    localparam int NUM_W       = CFG_W + CS_W;
    localparam int DVD_W       = NUM_W + 2;
    localparam int DVS_W       = DEN_W + 1;
    localparam int Q_W         = CFG_W;
    localparam int DIV_PER_STG = 2;
    localparam int DIV_STG     = (Q_W + DIV_PER_STG - 1) / DIV_PER_STG;
    localparam int SPIN_W      = Q_W + 1;
    localparam int SPIN_LAT    = SQRT_STG + DIV_STG + 2;

    // rotation
    localparam int CORDIC_STEPS = 16;
    localparam int CORD_PER_STG = 2;
    localparam int CORD_STG     = CORDIC_STEPS / CORD_PER_STG;
    localparam int ANG_W        = 32;
    localparam int Z_W          = ANG_W + 1;
    localparam int V_W          = AX_W + 19;
    localparam int GAIN_W       = 18;
    localparam int INV_GAIN     = 39797;
    localparam int PROD_W       = V_W + GAIN_W;
    localparam int VO_W         = AXIS_FRAC_BITS + 3;
    localparam int CMD_W        = VO_W + 1;
    localparam int ROT_LAT      = CORD_STG + 4;
    localparam int ROT_PAD      = SPIN_LAT - ROT_LAT;

    // wheel mixing
    localparam int RPM_W     = 17;
    localparam int RPM_LIMIT = 65535;
    localparam int WPROD_W   = CMD_W + CFG_W + 1;
    localparam int SUM_W     = WPROD_W - AXIS_FRAC_BITS + 1;

    // stream words
    localparam int IN_FIELDS_W  = 5 + 2 * AX_W + ANGLE_BITS + 1;
    localparam int IN_W         = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 4 * RPM_W + SPIN_W;
    localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [ANG_W-1:0] ATAN_TURN [CORDIC_STEPS] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_WHEEL = 2'd0,
        CFG_MAX_SPIN  = 2'd1,
        CFG_FALLOFF   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0]  max_wheel;
        logic [CFG_W-1:0]  max_spin;
        logic [COEF_W-1:0] coeff;
    } t_cfg;

    typedef struct packed {
        logic signed [CMD_W-1:0] fl;
        logic signed [CMD_W-1:0] fr;
        logic signed [CMD_W-1:0] bl;
        logic signed [CMD_W-1:0] br;
    } t_cmd;

endpackage

/* rtl/xdm_spin.sv */
// Spin rate pipeline: squared length, digit-by-digit root, restoring divider.
module xdm_spin import xdm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic signed [AX_W-1:0]   i_x,
    input  logic signed [AX_W-1:0]   i_y,
    input  logic                     i_req,
    input  t_cfg                     i_cfg,
    output logic                     o_valid,
    output logic signed [SPIN_W-1:0] o_spin
);

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic              req;
    } t_sq_st;

    typedef struct packed {
        logic [DVD_W-1:0] rem;
        logic [DVS_W-1:0] dvs;
        logic [Q_W-1:0]   q;
        logic             dz;
        logic             req;
    } t_dv_st;

    function automatic t_sq_st sq_step(input t_sq_st a);
        t_sq_st           b;
        logic [REM_W-1:0] rm;
        logic [REM_W-1:0] tr;
        b   = a;
        rm  = {a.rem[REM_W-3:0], a.rad[RAD_W-1 -: 2]};
        tr  = REM_W'({a.root, 2'b01});
        b.rad = a.rad << 2;
        if (rm >= tr) begin
            b.rem  = rm - tr;
            b.root = {a.root[ROOT_W-2:0], 1'b1};
        end else begin
            b.rem  = rm;
            b.root = {a.root[ROOT_W-2:0], 1'b0};
        end
        return b;
    endfunction

    function automatic t_dv_st dv_step(input t_dv_st a, input int k);
        t_dv_st           b;
        logic [DVD_W-1:0] sh;
        b  = a;
        sh = DVD_W'(a.dvs) << k;
        if (a.rem >= sh) begin
            b.rem = a.rem - sh;
            b.q   = {a.q[Q_W-2:0], 1'b1};
        end else begin
            b.q   = {a.q[Q_W-2:0], 1'b0};
        end
        return b;
    endfunction

    // squared length
    logic                       r_sq_v;
    logic [SQ_W-1:0]            r_sq;
    logic                       r_sq_req;
    logic signed [2*AX_W-1:0]   px;
    logic signed [2*AX_W-1:0]   py;
    logic signed [2*AX_W-1:0]   psum;

    always_comb begin
        px   = i_x * i_x;
        py   = i_y * i_y;
        psum = px + py;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v <= 1'b0;
        end else if (i_en) begin
            r_sq_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq     <= psum[SQ_W-1:0];
            r_sq_req <= i_req;
        end
    end

    // root, SQRT_PER_STG result bits per stage
    t_sq_st               sq_in  [SQRT_STG];
    t_sq_st               sq_nx  [SQRT_STG];
    t_sq_st               r_sqs  [SQRT_STG];
    logic [SQRT_STG-1:0]  r_sqv;

    for (genvar s = 0; s < SQRT_STG; s++) begin : g_sqrt
        if (s == 0) begin : g_first
            assign sq_in[s] = '{rad: {r_sq, {MAG_SHIFT{1'b0}}}, rem: '0, root: '0,
                                req: r_sq_req};
        end else begin : g_next
            assign sq_in[s] = r_sqs[s-1];
        end

        always_comb begin
            t_sq_st cur;
            cur = sq_in[s];
            for (int j = 0; j < SQRT_PER_STG; j++) begin
                if (s * SQRT_PER_STG + j < ROOT_W) begin
                    cur = sq_step(cur);
                end
            end
            sq_nx[s] = cur;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sqs[s] <= sq_nx[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sqv <= '0;
        end else if (i_en) begin
            r_sqv[0] <= r_sq_v;
            for (int i = 1; i < SQRT_STG; i++) begin
                r_sqv[i] <= r_sqv[i-1];
            end
        end
    end

    // divider operands: (2N + D) / (2D), rounds N/D half up
    logic             r_pr_v;
    t_dv_st           r_pr;
    logic [CS_W-1:0]  cs;
    logic [DEN_W-1:0] den;
    logic [NUM_W-1:0] num;

    always_comb begin
        cs  = {i_cfg.coeff, {AXIS_FRAC_BITS{1'b0}}};
        den = DEN_W'(cs) + DEN_W'(r_sqs[SQRT_STG-1].root);
        num = NUM_W'(i_cfg.max_spin) * NUM_W'(cs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pr_v <= 1'b0;
        end else if (i_en) begin
            r_pr_v <= r_sqv[SQRT_STG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pr.rem <= DVD_W'({num, 1'b0}) + DVD_W'(den);
            r_pr.dvs <= {den, 1'b0};
            r_pr.q   <= '0;
            r_pr.dz  <= (den == '0);
            r_pr.req <= r_sqs[SQRT_STG-1].req;
        end
    end

    t_dv_st              dv_in [DIV_STG];
    t_dv_st              dv_nx [DIV_STG];
    t_dv_st              r_dv  [DIV_STG];
    logic [DIV_STG-1:0]  r_dvv;

    for (genvar s = 0; s < DIV_STG; s++) begin : g_div
        if (s == 0) begin : g_first
            assign dv_in[s] = r_pr;
        end else begin : g_next
            assign dv_in[s] = r_dv[s-1];
        end

        always_comb begin
            t_dv_st cur;
            cur = dv_in[s];
            for (int j = 0; j < DIV_PER_STG; j++) begin
                if (s * DIV_PER_STG + j < Q_W) begin
                    cur = dv_step(cur, Q_W - 1 - (s * DIV_PER_STG + j));
                end
            end
            dv_nx[s] = cur;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[s] <= dv_nx[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvv <= '0;
        end else if (i_en) begin
            r_dvv[0] <= r_pr_v;
            for (int i = 1; i < DIV_STG; i++) begin
                r_dvv[i] <= r_dvv[i-1];
            end
        end
    end

    // zero denominator means zero coefficient and zero vector: full spin
    logic [Q_W-1:0] spin_mag;

    assign spin_mag = r_dv[DIV_STG-1].dz ? i_cfg.max_spin : r_dv[DIV_STG-1].q;
    assign o_spin   = r_dv[DIV_STG-1].req ? -$signed({1'b0, spin_mag}) : '0;
    assign o_valid  = r_dvv[DIV_STG-1];

    a_spin_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dvv[DIV_STG-1] && !r_dv[DIV_STG-1].dz) |-> (r_dv[DIV_STG-1].q <= i_cfg.max_spin))
        else $error("spin quotient above max spin");

endmodule

/* rtl/xdm_cordic.sv */
// Rotation pipeline: half-turn fold, CORDIC steps, gain correction, wheel commands.
module xdm_cordic import xdm_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic signed [AX_W-1:0] i_x,
    input  logic signed [AX_W-1:0] i_y,
    input  logic [ANGLE_BITS-1:0]  i_angle,
    input  logic                   i_cal,
    output logic                   o_valid,
    output t_cmd                   o_cmd
);

    typedef struct packed {
        logic signed [V_W-1:0] vx;
        logic signed [V_W-1:0] vy;
        logic signed [Z_W-1:0] z;
        logic                  cal;
    } t_rot;

    localparam logic signed [GAIN_W-1:0] INV_GAIN_S = GAIN_W'(INV_GAIN);
    localparam logic signed [PROD_W-1:0] HALF_LSB   = PROD_W'(1) <<< 31;
    localparam logic [ANG_W-1:0]         QUARTER    = ANG_W'(1) << (ANG_W - 2);

    function automatic t_rot rot_step(input t_rot a, input int i);
        t_rot                  b;
        logic signed [V_W-1:0] dx;
        logic signed [V_W-1:0] dy;
        logic signed [Z_W-1:0] at;
        b  = a;
        dx = a.vy >>> i;
        dy = a.vx >>> i;
        at = $signed({1'b0, ATAN_TURN[i]});
        if (!a.z[Z_W-1]) begin
            b.vx = a.vx - dx;
            b.vy = a.vy + dy;
            b.z  = a.z - at;
        end else begin
            b.vx = a.vx + dx;
            b.vy = a.vy - dy;
            b.z  = a.z + at;
        end
        return b;
    endfunction

    // fold the negated angle into a half turn around zero
    logic [ANG_W-1:0]      ang_neg;
    logic [ANG_W-1:0]      ang_chk;
    logic [ANG_W-1:0]      ang_fold;
    logic signed [V_W-1:0] xw;
    logic signed [V_W-1:0] yw;
    logic                  r_pre_v;
    t_rot                  r_pre;

    always_comb begin
        ang_neg  = '0 - {i_angle, {(ANG_W - ANGLE_BITS){1'b0}}};
        ang_chk  = ang_neg + QUARTER;
        ang_fold = ang_neg;
        xw       = V_W'(i_x) <<< MAG_SHIFT;
        yw       = V_W'(i_y) <<< MAG_SHIFT;
        if (ang_chk[ANG_W-1]) begin
            ang_fold[ANG_W-1] = ~ang_neg[ANG_W-1];
            xw = -xw;
            yw = -yw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_v <= 1'b0;
        end else if (i_en) begin
            r_pre_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pre.vx  <= xw;
            r_pre.vy  <= yw;
            r_pre.z   <= $signed({ang_fold[ANG_W-1], ang_fold});
            r_pre.cal <= i_cal;
        end
    end

    t_rot                 st_in [CORD_STG];
    t_rot                 st_nx [CORD_STG];
    t_rot                 r_st  [CORD_STG];
    logic [CORD_STG-1:0]  r_stv;

    for (genvar s = 0; s < CORD_STG; s++) begin : g_rot
        if (s == 0) begin : g_first
            assign st_in[s] = r_pre;
        end else begin : g_next
            assign st_in[s] = r_st[s-1];
        end

        always_comb begin
            t_rot cur;
            cur = st_in[s];
            for (int j = 0; j < CORD_PER_STG; j++) begin
                cur = rot_step(cur, s * CORD_PER_STG + j);
            end
            st_nx[s] = cur;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[s] <= st_nx[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stv <= '0;
        end else if (i_en) begin
            r_stv[0] <= r_pre_v;
            for (int i = 1; i < CORD_STG; i++) begin
                r_stv[i] <= r_stv[i-1];
            end
        end
    end

    // gain correction, then round to axis units
    logic                     r_gn_v;
    logic signed [PROD_W-1:0] r_px;
    logic signed [PROD_W-1:0] r_py;
    logic                     r_gn_cal;
    logic signed [PROD_W-1:0] rx;
    logic signed [PROD_W-1:0] ry;
    logic                     r_rd_v;
    logic signed [VO_W-1:0]   r_vx;
    logic signed [VO_W-1:0]   r_vy;
    logic                     r_out_v;
    t_cmd                     r_cmd;

    always_comb begin
        rx = r_px + HALF_LSB;
        ry = r_py + HALF_LSB;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gn_v  <= 1'b0;
            r_rd_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_gn_v  <= r_stv[CORD_STG-1];
            r_rd_v  <= r_gn_v;
            r_out_v <= r_rd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px     <= r_st[CORD_STG-1].vx * INV_GAIN_S;
            r_py     <= r_st[CORD_STG-1].vy * INV_GAIN_S;
            r_gn_cal <= r_st[CORD_STG-1].cal;
            // drop translation while the turret is uncalibrated
            r_vx     <= r_gn_cal ? $signed(rx[VO_W+31:32]) : '0;
            r_vy     <= r_gn_cal ? $signed(ry[VO_W+31:32]) : '0;
            r_cmd.fl <= CMD_W'(r_vx) + CMD_W'(r_vy);
            r_cmd.fr <= CMD_W'(r_vy) - CMD_W'(r_vx);
            r_cmd.bl <= CMD_W'(r_vx) - CMD_W'(r_vy);
            r_cmd.br <= -CMD_W'(r_vx) - CMD_W'(r_vy);
        end
    end

    assign o_valid = r_out_v;
    assign o_cmd   = r_cmd;

    a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pre_v |-> (r_pre.z[Z_W-1] == r_pre.z[Z_W-2]) && (r_pre.z[Z_W-2] == r_pre.z[Z_W-3]))
        else $error("folded angle outside a half turn");

endmodule

/* rtl/xdm_mix.sv */
// Wheel mixer: scale commands by wheel RPM, round, add spin, saturate.
module xdm_mix import xdm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  t_cmd                     i_cmd,
    input  logic signed [SPIN_W-1:0] i_spin,
    input  t_cfg                     i_cfg,
    output logic                     o_valid,
    output logic signed [RPM_W-1:0]  o_fl,
    output logic signed [RPM_W-1:0]  o_fr,
    output logic signed [RPM_W-1:0]  o_bl,
    output logic signed [RPM_W-1:0]  o_br,
    output logic signed [SPIN_W-1:0] o_spin
);

    localparam logic signed [WPROD_W-1:0] HALF  = WPROD_W'(1) <<< (AXIS_FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0]   LIM_P = SUM_W'(RPM_LIMIT);
    localparam logic signed [SUM_W-1:0]   LIM_N = -LIM_P;

    function automatic logic signed [RPM_W-1:0] wheel(input logic signed [WPROD_W-1:0] p,
                                                      input logic signed [SPIN_W-1:0] sp);
        logic signed [WPROD_W-1:0] t;
        logic signed [SUM_W-1:0]   s;
        t = p + HALF;
        s = SUM_W'($signed(t[WPROD_W-1:AXIS_FRAC_BITS])) + SUM_W'(sp);
        if (s > LIM_P) begin
            s = LIM_P;
        end else if (s < LIM_N) begin
            s = LIM_N;
        end
        return RPM_W'(s);
    endfunction

    logic signed [CMD_W:0]      scale;
    logic                       r_p_v;
    logic signed [WPROD_W-1:0]  r_pfl;
    logic signed [WPROD_W-1:0]  r_pfr;
    logic signed [WPROD_W-1:0]  r_pbl;
    logic signed [WPROD_W-1:0]  r_pbr;
    logic signed [SPIN_W-1:0]   r_p_spin;
    logic                       r_o_v;
    logic signed [RPM_W-1:0]    r_fl;
    logic signed [RPM_W-1:0]    r_fr;
    logic signed [RPM_W-1:0]    r_bl;
    logic signed [RPM_W-1:0]    r_br;
    logic signed [SPIN_W-1:0]   r_spin;

    assign scale = $signed((CMD_W + 1)'(i_cfg.max_wheel));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
            r_o_v <= 1'b0;
        end else if (i_en) begin
            r_p_v <= i_valid;
            r_o_v <= r_p_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pfl    <= i_cmd.fl * scale;
            r_pfr    <= i_cmd.fr * scale;
            r_pbl    <= i_cmd.bl * scale;
            r_pbr    <= i_cmd.br * scale;
            r_p_spin <= i_spin;
            r_fl     <= wheel(r_pfl, r_p_spin);
            r_fr     <= wheel(r_pfr, r_p_spin);
            r_bl     <= wheel(r_pbl, r_p_spin);
            r_br     <= wheel(r_pbr, r_p_spin);
            r_spin   <= r_p_spin;
        end
    end

    assign o_valid = r_o_v;
    assign o_fl    = r_fl;
    assign o_fr    = r_fr;
    assign o_bl    = r_bl;
    assign o_br    = r_br;
    assign o_spin  = r_spin;

endmodule

/* rtl/turret_centric_xdrive_mixer_unit.sv */
// Top level of the turret-centric X-drive mixer: entry stage, spin and rotation paths, mixer.
//
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   s_axis_tdata, one drive command word
//  m_axis    out        m_axis_tvalid/m_axis_tready   m_axis_tdata, four wheel RPMs + spin
//  cfg       in         i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data
//
//  One word is accepted per cycle while the output is not held; its result passes the entry register,
//  14 spin path stages (squared length, root, divider operands, divider) with the rotation path
//  alongside, and 2 mixer stages. The divider, at two quotient bits per stage, sets the depth.
//  All stages advance together whenever the output register is empty or being taken;
//  a held output stalls the whole pipeline and the input, nothing is lost or repeated.
//  Reset clears stage valid bits and loads the register defaults; config is always ready.
module turret_centric_xdrive_mixer_unit import xdm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // key_forward, key_back, key_left, key_right, spin_request, stick_x, stick_y,
    // turret_angle, turret_calibrated
    input  logic [IN_W-1:0]      s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // rpm_front_left, rpm_front_right, rpm_back_left, rpm_back_right, spin_rpm, zero pad
    output logic [OUT_W-1:0]     m_axis_tdata,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int POS_SX  = 5;
    localparam int POS_SY  = POS_SX + AX_W;
    localparam int POS_ANG = POS_SY + AX_W;
    localparam int POS_CAL = POS_ANG + ANGLE_BITS;

    localparam logic signed [AX_W+1:0] AX_ONE  = (AX_W + 2)'(1 << AXIS_FRAC_BITS);
    localparam logic signed [AX_W+1:0] AX_ZERO = '0;

    function automatic logic signed [AX_W-1:0] clamp_axis(input logic pos, input logic neg,
                                                          input logic signed [AX_W-1:0] stick);
        logic signed [AX_W+1:0] s;
        s = (AX_W + 2)'(stick) + (pos ? AX_ONE : AX_ZERO) - (neg ? AX_ONE : AX_ZERO);
        if (s > AX_ONE) begin
            s = AX_ONE;
        end else if (s < -AX_ONE) begin
            s = -AX_ONE;
        end
        return AX_W'(s);
    endfunction

    // configuration
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_wheel <= CFG_W'(8000);
            r_cfg.max_spin  <= CFG_W'(4000);
            r_cfg.coeff     <= COEF_W'(512);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAX_WHEEL: r_cfg.max_wheel <= i_cfg_data;
                CFG_MAX_SPIN:  r_cfg.max_spin  <= i_cfg_data;
                CFG_FALLOFF:   r_cfg.coeff     <= i_cfg_data[COEF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // global advance
    logic adv;
    logic out_v;

    assign adv           = !out_v || m_axis_tready;
    assign s_axis_tready = adv;

    // entry stage
    logic                   r_s0_v;
    logic signed [AX_W-1:0] r_s0_x;
    logic signed [AX_W-1:0] r_s0_y;
    logic                   r_s0_req;
    logic [ANGLE_BITS-1:0]  r_s0_ang;
    logic                   r_s0_cal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (adv) begin
            r_s0_v <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s0_x   <= clamp_axis(s_axis_tdata[0], s_axis_tdata[1],
                                   $signed(s_axis_tdata[POS_SX +: AX_W]));
            r_s0_y   <= clamp_axis(s_axis_tdata[3], s_axis_tdata[2],
                                   $signed(s_axis_tdata[POS_SY +: AX_W]));
            r_s0_req <= s_axis_tdata[4];
            r_s0_ang <= s_axis_tdata[POS_ANG +: ANGLE_BITS];
            r_s0_cal <= s_axis_tdata[POS_CAL];
        end
    end

    // spin path
    logic                     spin_v;
    logic signed [SPIN_W-1:0] spin;

    xdm_spin u_spin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_s0_v),
        .i_x     (r_s0_x),
        .i_y     (r_s0_y),
        .i_req   (r_s0_req),
        .i_cfg   (r_cfg),
        .o_valid (spin_v),
        .o_spin  (spin)
    );

    // rotation path, padded to the spin path depth
    logic rot_v;
    t_cmd rot_cmd;

    xdm_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_s0_v),
        .i_x     (r_s0_x),
        .i_y     (r_s0_y),
        .i_angle (r_s0_ang),
        .i_cal   (r_s0_cal),
        .o_valid (rot_v),
        .o_cmd   (rot_cmd)
    );

    t_cmd               r_dly     [ROT_PAD];
    logic [ROT_PAD-1:0] r_dly_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dly_v <= '0;
        end else if (adv) begin
            r_dly_v[0] <= rot_v;
            for (int i = 1; i < ROT_PAD; i++) begin
                r_dly_v[i] <= r_dly_v[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dly[0] <= rot_cmd;
            for (int i = 1; i < ROT_PAD; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end

    // mixer and output register
    logic signed [RPM_W-1:0]  rpm_fl;
    logic signed [RPM_W-1:0]  rpm_fr;
    logic signed [RPM_W-1:0]  rpm_bl;
    logic signed [RPM_W-1:0]  rpm_br;
    logic signed [SPIN_W-1:0] spin_out;

    xdm_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (spin_v),
        .i_cmd   (r_dly[ROT_PAD-1]),
        .i_spin  (spin),
        .i_cfg   (r_cfg),
        .o_valid (out_v),
        .o_fl    (rpm_fl),
        .o_fr    (rpm_fr),
        .o_bl    (rpm_bl),
        .o_br    (rpm_br),
        .o_spin  (spin_out)
    );

    assign m_axis_tvalid = out_v;
    assign m_axis_tdata  = {(OUT_W - OUT_FIELDS_W)'(0), spin_out, rpm_br, rpm_bl, rpm_fr,
                            rpm_fl};

    a_paths_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        spin_v == r_dly_v[ROT_PAD-1])
        else $error("spin and rotation paths out of step");

    a_rpm_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_v |-> (rpm_fl != {1'b1, {(RPM_W-1){1'b0}}}) && (rpm_fr != {1'b1, {(RPM_W-1){1'b0}}})
               && (rpm_bl != {1'b1, {(RPM_W-1){1'b0}}}) && (rpm_br != {1'b1, {(RPM_W-1){1'b0}}}))
        else $error("wheel RPM beyond saturation limit");

    a_spin_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_v |-> (spin_out[SPIN_W-1] || (spin_out == '0)))
        else $error("spin contribution positive");

endmodule

/* tb/turret_centric_xdrive_mixer_unit_test.sv */
// Self-checking testbench of the turret-centric X-drive mixer: stream stimulus and scoreboard.
module turret_centric_xdrive_mixer_unit_test;
    import xdm_pkg::*;

    typedef struct packed {
        logic [RPM_W-1:0]  fl;
        logic [RPM_W-1:0]  fr;
        logic [RPM_W-1:0]  bl;
        logic [RPM_W-1:0]  br;
        logic [SPIN_W-1:0] spin;
    } t_wheel_set;

    class wheel_scoreboard;
        t_wheel_set expected_rpms[$];
        longint     max_wheel = 8000;
        longint     max_spin  = 4000;
        longint     coeff     = 512;
        int         errors    = 0;

        function void set_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_MAX_WHEEL: max_wheel = val;
                CFG_MAX_SPIN:  max_spin  = val;
                CFG_FALLOFF:   coeff     = val[COEF_W-1:0];
                default: ;
            endcase
        endfunction

        function longint root_floor(longint unsigned v);
            longint unsigned res;
            longint unsigned bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv >>= 2;
            while (bitv != 0) begin
                if (v >= res + bitv) begin
                    v   = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv >>= 2;
            end
            return longint'(res);
        endfunction

        function logic [RPM_W-1:0] wheel_target(longint cmd, longint spin);
            longint r;
            r = ((cmd * max_wheel + 1024) >>> AXIS_FRAC_BITS) + spin;
            if (r > RPM_LIMIT) r = RPM_LIMIT;
            if (r < -RPM_LIMIT) r = -RPM_LIMIT;
            return r[RPM_W-1:0];
        endfunction

        function void note_command(logic [IN_W-1:0] w);
            longint     x, y, vx, vy, mag, cs, den, spin, spin_out, bx, by, z, dx, dy;
            logic [31:0] r;
            logic [31:0] rq;
            t_wheel_set e;
            x = 0; y = 0; vx = 0; vy = 0; spin_out = 0;
            if (w[0]) x += 2048;
            if (w[1]) x -= 2048;
            if (w[2]) y -= 2048;
            if (w[3]) y += 2048;
            x += longint'($signed(w[17:5]));
            y += longint'($signed(w[30:18]));
            if (x > 2048) x = 2048;
            if (x < -2048) x = -2048;
            if (y > 2048) y = 2048;
            if (y < -2048) y = -2048;
            mag = root_floor((x * x + y * y) << 16);
            cs  = coeff << AXIS_FRAC_BITS;
            den = cs + mag;
            spin = (den == 0) ? max_spin : (2 * max_spin * cs + den) / (2 * den);
            if (w[4]) spin_out = -spin;
            if (w[47]) begin
                r  = 32'd0 - {w[46:31], 16'd0};
                bx = x * 65536;
                by = y * 65536;
                rq = r + 32'h4000_0000;
                if (rq[31]) begin
                    bx = -bx;
                    by = -by;
                    r  = r - 32'h8000_0000;
                end
                z = longint'($signed(r));
                for (int i = 0; i < CORDIC_STEPS; i++) begin
                    dx = by >>> i;
                    dy = bx >>> i;
                    if (z >= 0) begin
                        bx -= dx; by += dy; z -= longint'(ATAN_TURN[i]);
                    end else begin
                        bx += dx; by -= dy; z += longint'(ATAN_TURN[i]);
                    end
                end
                vx = (bx * INV_GAIN + (64'sd1 <<< 31)) >>> 32;
                vy = (by * INV_GAIN + (64'sd1 <<< 31)) >>> 32;
            end
            e.fl   = wheel_target(vx + vy, spin_out);
            e.fr   = wheel_target(-vx + vy, spin_out);
            e.bl   = wheel_target(vx - vy, spin_out);
            e.br   = wheel_target(-vx - vy, spin_out);
            e.spin = spin_out[SPIN_W-1:0];
            expected_rpms.push_back(e);
        endfunction

        function void check_result(logic [OUT_W-1:0] d);
            t_wheel_set got, e;
            got.fl   = d[16:0];
            got.fr   = d[33:17];
            got.bl   = d[50:34];
            got.br   = d[67:51];
            got.spin = d[82:68];
            if (expected_rpms.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word %h", d);
                return;
            end
            e = expected_rpms.pop_front();
            if (got != e) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch exp fl=%0d fr=%0d bl=%0d br=%0d spin=%0d got fl=%0d fr=%0d bl=%0d br=%0d spin=%0d",
                        $signed(e.fl), $signed(e.fr), $signed(e.bl), $signed(e.br),
                        $signed(e.spin), $signed(got.fl), $signed(got.fr),
                        $signed(got.bl), $signed(got.br), $signed(got.spin));
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // key_forward, key_back, key_left, key_right, spin_request, stick_x, stick_y,
    // turret_angle, turret_calibrated
    logic [IN_W-1:0]      s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // rpm_front_left, rpm_front_right, rpm_back_left, rpm_back_right, spin_rpm, zero pad
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    wheel_scoreboard sb = new;
    bit     no_idle = 1'b0;
    longint cycles = 0;

    turret_centric_xdrive_mixer_unit u_dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 600000) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int idle_gap();
        return no_idle ? 0 : $urandom_range(0, 19);
    endfunction

    task automatic send_command(logic [IN_W-1:0] w);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_command(w);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
        s_axis_tvalid <= 1'b0;
        i_cfg_valid   <= 1'b1;
        i_cfg_index   <= idx;
        i_cfg_data    <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    // hold config writes until the pipeline has drained
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_rpms.size() != 0) @(posedge i_clk);
        repeat (25) @(posedge i_clk);
    endtask

    function automatic logic [IN_W-1:0] pack_cmd(logic [4:0] keys, logic [12:0] sx,
                                                  logic [12:0] sy, logic [15:0] ang,
                                                  logic cal);
        return {cal, ang, sy, sx, keys};
    endfunction

    function automatic logic [IN_W-1:0] random_cmd();
        logic [12:0] sx, sy;
        if ($urandom_range(0, 9) < 7) begin
            sx = 13'($signed($urandom_range(0, 4096)) - 2048);
            sy = 13'($signed($urandom_range(0, 4096)) - 2048);
            if ($urandom_range(0, 3) == 0) sx = '0;
            if ($urandom_range(0, 3) == 0) sy = '0;
        end else begin
            sx = 13'($urandom);
            sy = 13'($urandom);
        end
        return pack_cmd(5'($urandom), sx, sy, 16'($urandom), $urandom_range(0, 7) != 0);
    endfunction

    // receiver side: random backpressure, check every accepted word
    initial begin
        int gap;
        forever begin
            gap = idle_gap();
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_result(m_axis_tdata);
        end
    end

    initial begin
        logic [15:0] angles [5] = '{16'd0, 16'd16384, 16'd32768, 16'd49152, 16'd65535};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, keys, angles, out-of-range sticks
        send_command(pack_cmd(5'b10000, 13'd0, 13'd0, 16'd0, 1'b1));
        send_command(pack_cmd(5'b11111, 13'd0, 13'd0, 16'd0, 1'b1));
        send_command(pack_cmd(5'b00001, 13'd0, 13'd0, 16'd0, 1'b0));
        send_command(pack_cmd(5'b10010, 13'd0, 13'd0, 16'd8192, 1'b1));
        send_command(pack_cmd(5'b00100, 13'd0, 13'd0, 16'd4096, 1'b1));
        send_command(pack_cmd(5'b11000, 13'd0, 13'd0, 16'd12345, 1'b1));
        send_command(pack_cmd(5'b10000, 13'h1000, 13'h0FFF, 16'd0, 1'b1));
        send_command(pack_cmd(5'b10101, 13'h0800, 13'h1800, 16'd65535, 1'b1));
        send_command(pack_cmd(5'b00000, 13'h1FFF, 13'h0001, 16'd32767, 1'b1));
        foreach (angles[i]) begin
            send_command(pack_cmd(5'b10001, 13'h0400, 13'h1C00, angles[i], 1'b1));
            send_command(pack_cmd(5'b00110, 13'h0800, 13'h0800, angles[i], 1'b1));
        end
        drain();

        // zero wheel scale, then zero coefficient
        write_reg(CFG_MAX_WHEEL, 14'd0);
        write_reg(t_cfg_idx'(3), 14'h3FFF);
        send_command(pack_cmd(5'b10001, 13'h0800, 13'd0, 16'd100, 1'b1));
        send_command(pack_cmd(5'b10000, 13'd0, 13'd0, 16'd0, 1'b1));
        drain();
        write_reg(CFG_MAX_WHEEL, 14'h3FFF);
        write_reg(CFG_MAX_SPIN, 14'h3FFF);
        write_reg(CFG_FALLOFF, 14'd0);
        send_command(pack_cmd(5'b10000, 13'd0, 13'd0, 16'd0, 1'b1));
        send_command(pack_cmd(5'b11001, 13'h0800, 13'h0800, 16'd7000, 1'b1));
        send_command(pack_cmd(5'b10000, 13'd1, 13'd0, 16'd0, 1'b0));
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_MAX_WHEEL, 14'd8000);
                    write_reg(CFG_MAX_SPIN, 14'd4000);
                    write_reg(CFG_FALLOFF, 14'd512);
                end
                1: begin
                    write_reg(CFG_MAX_WHEEL, 14'h3FFF);
                    write_reg(CFG_MAX_SPIN, 14'h3FFF);
                    write_reg(CFG_FALLOFF, 14'd4095);
                end
                2: begin
                    write_reg(CFG_MAX_WHEEL, 14'd0);
                    write_reg(CFG_MAX_SPIN, 14'd0);
                    write_reg(CFG_FALLOFF, 14'd1);
                end
                default: begin
                    write_reg(CFG_MAX_WHEEL, 14'($urandom_range(0, 16383)));
                    write_reg(CFG_MAX_SPIN, 14'($urandom_range(0, 16383)));
                    write_reg(CFG_FALLOFF, 14'($urandom_range(0, 4095)));
                end
            endcase
            for (int n = 0; n < 200; n++) begin
                if (n % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
                send_command(random_cmd());
            end
            no_idle = 1'b0;
            drain();
        end

        if (sb.errors == 0 && sb.expected_rpms.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
